// ===== rtl/bndr_pkg.sv =====
// Shared types, constants and saturation helpers for the BNDR-LMS adaptive filter.
// Used by bndr_mul, bndr_div and bndr_lms_adaptive_fir; depends on nothing else.
`default_nettype none

package bndr_pkg;

   // field and datapath widths (sized for the largest supported tap count)
   localparam int SAMPLE_W  = 16;
   localparam int STEP_W    = 16;
   localparam int COEF_W    = 32;
   localparam int ENERGY_W  = 40;
   localparam int YACC_W    = 56;
   localparam int SHIFTED_W = 30;
   localparam int OPA_W     = 40;
   localparam int OPB_W     = 30;
   localparam int PROD_W    = OPA_W + OPB_W;
   localparam int BC_W      = 58;
   localparam int NUM_W     = 46;
   localparam int DEN_W     = 57;
   localparam int WEIGHT_W  = 40;
   localparam int QUOT_W    = 44;
   localparam int FRAC_BITS = 25;
   localparam int CNT_W     = 6;
   localparam int SUB_W     = 3;
   localparam int DELTA_W   = 42;

   localparam logic [DEN_W-1:0]           EPS_Q40    = 57'd109951163;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 40'sh7F_FFFF_FFFF;

   // register map
   localparam int            CSR_ADDR_W    = 3;
   localparam int            CSR_DATA_W    = 32;
   localparam logic [0:0]    REG_STEP_SIZE = 1'b0;
   localparam logic [STEP_W-1:0] STEP_RESET = 16'd3277;

   // sub-step codes of the dot product pass
   localparam logic [SUB_W-1:0] DOT_UV = 3'd0;
   localparam logic [SUB_W-1:0] DOT_UU = 3'd1;
   localparam logic [SUB_W-1:0] DOT_VV = 3'd2;
   localparam logic [SUB_W-1:0] DOT_UW = 3'd3;
   localparam logic [SUB_W-1:0] DOT_VW = 3'd4;

   // sub-step codes of the determinant and numerator pass
   localparam logic [SUB_W-1:0] DET_BC  = 3'd0;
   localparam logic [SUB_W-1:0] DET_AA  = 3'd1;
   localparam logic [SUB_W-1:0] DET_E1C = 3'd2;
   localparam logic [SUB_W-1:0] DET_E2A = 3'd3;
   localparam logic [SUB_W-1:0] DET_E2B = 3'd4;
   localparam logic [SUB_W-1:0] DET_E1A = 3'd5;

   // sub-step codes of the coefficient update pass
   localparam logic [SUB_W-1:0] UPD_WU    = 3'd0;
   localparam logic [SUB_W-1:0] UPD_WV    = 3'd1;
   localparam logic [SUB_W-1:0] UPD_SUM   = 3'd2;
   localparam logic [SUB_W-1:0] UPD_ROUND = 3'd3;
   localparam logic [SUB_W-1:0] UPD_STEP  = 3'd4;
   localparam logic [SUB_W-1:0] UPD_DELTA = 3'd5;
   localparam logic [SUB_W-1:0] UPD_WRITE = 3'd6;

   // destination of a product, carried alongside it through the multiplier
   typedef enum logic [3:0] {
      TAG_NONE, TAG_A, TAG_B, TAG_C, TAG_Y1, TAG_Y2,
      TAG_BC, TAG_AA, TAG_E1C, TAG_E2A, TAG_E2B, TAG_E1A,
      TAG_WU, TAG_WV, TAG_STP
   } tag_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DOT, ST_DOT_END, ST_ERR, ST_DET, ST_DET_END,
      ST_DIV_A_GO, ST_DIV_A_WAIT, ST_DIV_B_GO, ST_DIV_B_WAIT,
      ST_UPD, ST_UPD_END, ST_OUT
   } state_type;

   typedef struct packed {
      tag_type                  tag;
      logic signed [OPA_W-1:0]  op_a;
      logic signed [OPB_W-1:0]  op_b;
   } mul_req_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // saturate a 29-bit signed value to 16 bits
   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [28:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 29'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -29'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // saturate a 43-bit signed value to 32 bits
   function automatic logic signed [COEF_W-1:0] sat32(input logic signed [42:0] v);
      logic signed [COEF_W-1:0] r;
      if (v > 43'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -43'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[COEF_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bndr_mul.sv =====
// Shared signed multiplier with registered product and destination tag.
// Depends on bndr_pkg for operand widths and the tag type.
`default_nettype none

module bndr_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  bndr_pkg::mul_req_type               req,
   output bndr_pkg::tag_type                   tag,
   output logic signed [bndr_pkg::PROD_W-1:0]  prod
);
   import bndr_pkg::*;

   tag_type                  tag_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // form the full-width product
   assign prod_in = req.op_a * req.op_b;

   // register the product; the tag says where it goes next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= TAG_NONE;
      end else begin
         tag_ff <= req.tag;
      end
      prod_ff <= prod_in;
   end

   assign tag  = tag_ff;
   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== rtl/bndr_div.sv =====
// Radix-2 restoring divider for the step weights: |num| * 2^25 / den, saturated.
// Depends on bndr_pkg for widths, the weight limit and the control structs.
`default_nettype none

module bndr_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bndr_pkg::div_ctl_type                  ctl,
   input  logic signed [bndr_pkg::NUM_W-1:0]      num,
   input  logic [bndr_pkg::DEN_W-1:0]             den,
   output bndr_pkg::div_stat_type                 stat,
   output logic signed [bndr_pkg::WEIGHT_W-1:0]   quot
);
   import bndr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [QUOT_W-1:0]    sh_ff, sh_in;
   logic [QUOT_W-1:0]    q_ff, q_in;

   logic [NUM_W-1:0]     mag;
   logic [DEN_W+1:0]     trial;
   logic                 ge;
   logic [WEIGHT_W-1:0]  sat;

   assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign trial = {1'b0, rem_ff, sh_ff[QUOT_W-1]} - {2'b00, den_ff};
   assign ge    = ~trial[DEN_W+1];

   // load on start, then one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUOT_W);
         neg_in  = num[NUM_W-1];
         rem_in  = DEN_W'(mag[NUM_W-2:QUOT_W-FRAC_BITS]);
         den_in  = den;
         sh_in   = {mag[QUOT_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = ge ? trial[DEN_W-1:0] : {rem_ff[DEN_W-2:0], sh_ff[QUOT_W-1]};
         q_in   = {q_ff[QUOT_W-2:0], ge};
         sh_in  = {sh_ff[QUOT_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
   end

   // clamp the magnitude and restore the sign
   assign sat  = (q_ff > QUOT_W'(WEIGHT_MAX)) ? WEIGHT_MAX : q_ff[WEIGHT_W-1:0];
   assign quot = neg_ff ? WEIGHT_W'(-$signed(sat)) : $signed(sat);

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/bndr_lms_adaptive_fir.sv =====
// Binormalized data-reusing LMS adaptive FIR filter, top level.
// Holds the sequencer, tap line, coefficients and register port;
// uses bndr_pkg, bndr_mul and bndr_div.
//
// Usage:
//   req channel (req_valid/req_ready) takes one item: a Q1.15 sample and its
//   Q1.15 desired value. rsp channel (rsp_valid/rsp_ready) returns one item
//   per input: the a-priori filter output and the error, both saturated.
//   The APB-style csr port holds step_size (byte address 0), to be written
//   while the block is idle (not enforced by it); pready is always high.
// Operation:
//   One item at a time: five products per tap in the dot product pass and
//   three per tap in the update pass, all through one 40x30 multiplier,
//   plus two divisions in the serial divider.
//   req_ready rises again the cycle after the result item is taken.
// Reset:
//   Clears the tap line, coefficients and previous desired value, and loads
//   step_size with 3277. A stalled rsp_ready holds the result and the block.
`default_nettype none

module bndr_lms_adaptive_fir #(
   parameter int TAPS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [bndr_pkg::SAMPLE_W-1:0]     req_sample_in,
   input  logic signed [bndr_pkg::SAMPLE_W-1:0]     req_desired_in,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [bndr_pkg::SAMPLE_W-1:0]     rsp_filter_out,
   output logic signed [bndr_pkg::SAMPLE_W-1:0]     rsp_error_out,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [bndr_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [bndr_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic [bndr_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);
   import bndr_pkg::*;

   localparam int                IDX_W    = $clog2(TAPS);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TAPS - 1);

   // sequencer
   state_type           state_ff, state_in;
   logic [SUB_W-1:0]    sub_ff, sub_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   // filter state
   logic signed [SAMPLE_W-1:0] tap_ff  [0:TAPS];
   logic signed [SAMPLE_W-1:0] tap_in  [0:TAPS];
   logic signed [COEF_W-1:0]   coef_ff [0:TAPS-1];
   logic signed [COEF_W-1:0]   coef_in [0:TAPS-1];
   logic signed [SAMPLE_W-1:0] prev_d_ff, prev_d_in;
   logic [STEP_W-1:0]          step_ff, step_in;

   // working registers
   logic signed [SAMPLE_W-1:0]  d1_ff, d1_in, d2_ff, d2_in;
   logic signed [ENERGY_W-1:0]  acc_a_ff, acc_a_in, acc_b_ff, acc_b_in, acc_c_ff, acc_c_in;
   logic signed [YACC_W-1:0]    y1_ff, y1_in, y2_ff, y2_in;
   logic signed [SHIFTED_W-1:0] as_ff, as_in, bs_ff, bs_in, cs_ff, cs_in;
   logic signed [SAMPLE_W-1:0]  e1_ff, e1_in, e2_ff, e2_in, fo_ff, fo_in;
   logic signed [BC_W-1:0]      bc_ff, bc_in;
   logic [DEN_W-1:0]            den_ff, den_in;
   logic signed [NUM_W-1:0]     tmp_ff, tmp_in, numa_ff, numa_in, numb_ff, numb_in;
   logic signed [WEIGHT_W-1:0]  wa_ff, wa_in, wb_ff, wb_in;
   logic signed [YACC_W-1:0]    s_ff, s_in;
   logic signed [WEIGHT_W-1:0]  s28_ff, s28_in;
   logic signed [DELTA_W-1:0]   delta_ff, delta_in;

   // control decode
   logic         tap_rot, coef_rot, coef_wr;
   mul_req_type  mul_req;
   tag_type      mul_tag;
   logic signed [PROD_W-1:0] mul_prod;
   div_ctl_type  div_ctl;
   div_stat_type div_stat;
   logic signed [WEIGHT_W-1:0] div_quot;

   // datapath helpers
   logic signed [YACC_W-1:0]   y1r, y2r;
   logic signed [27:0]         y1q, y2q;
   logic signed [BC_W-1:0]     det;
   logic signed [YACC_W:0]     sr;
   logic signed [49:0]         s_rnd;
   logic signed [BC_W-1:0]     dr;
   logic signed [42:0]         coef_sum;
   logic signed [COEF_W-1:0]   coef_new;
   logic                       csr_wr;

   logic                       last_sub;

   bndr_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .tag   (mul_tag),
      .prod  (mul_prod)
   );

   bndr_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   ((state_ff == ST_DIV_B_GO) ? numb_ff : numa_ff),
      .den   (den_ff),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // last sub-step of the current pass
   always_comb begin
      case (state_ff)
         ST_DOT:  last_sub = (sub_ff == DOT_VW);
         ST_DET:  last_sub = (sub_ff == DET_E1A);
         ST_UPD:  last_sub = (sub_ff == UPD_WRITE);
         default: last_sub = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_DOT;
         ST_DOT:        if (last_sub && idx_ff == LAST_IDX) state_in = ST_DOT_END;
         ST_DOT_END:    state_in = ST_ERR;
         ST_ERR:        state_in = ST_DET;
         ST_DET:        if (last_sub) state_in = ST_DET_END;
         ST_DET_END:    state_in = ST_DIV_A_GO;
         ST_DIV_A_GO:   state_in = ST_DIV_A_WAIT;
         ST_DIV_A_WAIT: if (div_stat.done) state_in = ST_DIV_B_GO;
         ST_DIV_B_GO:   state_in = ST_DIV_B_WAIT;
         ST_DIV_B_WAIT: if (div_stat.done) state_in = ST_UPD;
         ST_UPD:        if (last_sub && idx_ff == LAST_IDX) state_in = ST_UPD_END;
         ST_UPD_END:    state_in = ST_OUT;
         ST_OUT:        if (rsp_ready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake, multiplier issue, divider start, rotations
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      rsp_valid     = (state_ff == ST_OUT);
      div_ctl.start = (state_ff == ST_DIV_A_GO) || (state_ff == ST_DIV_B_GO);
      tap_rot       = ((state_ff == ST_DOT || state_ff == ST_UPD) && last_sub) ||
                      (state_ff == ST_DOT_END) || (state_ff == ST_UPD_END);
      coef_rot      = (state_ff == ST_DOT || state_ff == ST_UPD) && last_sub;
      coef_wr       = (state_ff == ST_UPD);
      mul_req.tag   = TAG_NONE;
      mul_req.op_a  = OPA_W'(tap_ff[0]);
      mul_req.op_b  = OPB_W'(tap_ff[1]);
      case (state_ff)
         ST_DOT: begin
            case (sub_ff)
               DOT_UV: begin
                  mul_req.tag = TAG_A;
               end
               DOT_UU: begin
                  mul_req.tag  = TAG_B;
                  mul_req.op_b = OPB_W'(tap_ff[0]);
               end
               DOT_VV: begin
                  mul_req.tag  = TAG_C;
                  mul_req.op_a = OPA_W'(tap_ff[1]);
               end
               DOT_UW: begin
                  mul_req.tag  = TAG_Y1;
                  mul_req.op_a = OPA_W'(coef_ff[0]);
                  mul_req.op_b = OPB_W'(tap_ff[0]);
               end
               DOT_VW: begin
                  mul_req.tag  = TAG_Y2;
                  mul_req.op_a = OPA_W'(coef_ff[0]);
               end
               default: ;
            endcase
         end
         ST_DET: begin
            case (sub_ff)
               DET_BC: begin
                  mul_req.tag  = TAG_BC;
                  mul_req.op_a = OPA_W'(bs_ff);
                  mul_req.op_b = cs_ff;
               end
               DET_AA: begin
                  mul_req.tag  = TAG_AA;
                  mul_req.op_a = OPA_W'(as_ff);
                  mul_req.op_b = as_ff;
               end
               DET_E1C: begin
                  mul_req.tag  = TAG_E1C;
                  mul_req.op_a = OPA_W'(cs_ff);
                  mul_req.op_b = OPB_W'(e1_ff);
               end
               DET_E2A: begin
                  mul_req.tag  = TAG_E2A;
                  mul_req.op_a = OPA_W'(as_ff);
                  mul_req.op_b = OPB_W'(e2_ff);
               end
               DET_E2B: begin
                  mul_req.tag  = TAG_E2B;
                  mul_req.op_a = OPA_W'(bs_ff);
                  mul_req.op_b = OPB_W'(e2_ff);
               end
               DET_E1A: begin
                  mul_req.tag  = TAG_E1A;
                  mul_req.op_a = OPA_W'(as_ff);
                  mul_req.op_b = OPB_W'(e1_ff);
               end
               default: ;
            endcase
         end
         ST_UPD: begin
            case (sub_ff)
               UPD_WU: begin
                  mul_req.tag  = TAG_WU;
                  mul_req.op_a = wa_ff;
                  mul_req.op_b = OPB_W'(tap_ff[0]);
               end
               UPD_WV: begin
                  mul_req.tag  = TAG_WV;
                  mul_req.op_a = wb_ff;
               end
               UPD_STEP: begin
                  mul_req.tag  = TAG_STP;
                  mul_req.op_a = s28_ff;
                  mul_req.op_b = OPB_W'($signed({1'b0, step_ff}));
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // rounding and saturation helpers
   assign y1r      = y1_ff + (YACC_W'(1) <<< 27);
   assign y2r      = y2_ff + (YACC_W'(1) <<< 27);
   assign y1q      = $signed(y1r[YACC_W-1:28]);
   assign y2q      = $signed(y2r[YACC_W-1:28]);
   assign det      = bc_ff - $signed(mul_prod[BC_W-1:0]);
   assign sr       = (YACC_W+1)'(s_ff) + (YACC_W+1)'(64);
   assign s_rnd    = $signed(sr[YACC_W:7]);
   assign dr       = $signed(mul_prod[BC_W-1:0]) + BC_W'(32768);
   assign coef_sum = 43'(coef_ff[0]) + 43'(delta_ff);
   assign coef_new = sat32(coef_sum);
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // datapath next values
   always_comb begin
      tap_in    = tap_ff;
      coef_in   = coef_ff;
      prev_d_in = prev_d_ff;
      step_in   = step_ff;
      d1_in     = d1_ff;
      d2_in     = d2_ff;
      acc_a_in  = acc_a_ff;
      acc_b_in  = acc_b_ff;
      acc_c_in  = acc_c_ff;
      y1_in     = y1_ff;
      y2_in     = y2_ff;
      as_in     = as_ff;
      bs_in     = bs_ff;
      cs_in     = cs_ff;
      e1_in     = e1_ff;
      e2_in     = e2_ff;
      fo_in     = fo_ff;
      bc_in     = bc_ff;
      den_in    = den_ff;
      tmp_in    = tmp_ff;
      numa_in   = numa_ff;
      numb_in   = numb_ff;
      wa_in     = wa_ff;
      wb_in     = wb_ff;
      s_in      = s_ff;
      s28_in    = s28_ff;
      delta_in  = delta_ff;

      // write step size
      if (csr_wr && csr_paddr[CSR_ADDR_W-1:2] == REG_STEP_SIZE) begin
         step_in = csr_pwdata[STEP_W-1:0];
      end

      // take an item: shift the sample in, clear the sums
      if (req_valid && req_ready) begin
         tap_in[0] = req_sample_in;
         for (int k = 1; k <= TAPS; k++) begin
            tap_in[k] = tap_ff[k-1];
         end
         d1_in     = req_desired_in;
         d2_in     = prev_d_ff;
         prev_d_in = req_desired_in;
         acc_a_in  = '0;
         acc_b_in  = '0;
         acc_c_in  = '0;
         y1_in     = '0;
         y2_in     = '0;
      end

      // rotate the tap line one place toward the head
      if (tap_rot) begin
         for (int k = 0; k < TAPS; k++) begin
            tap_in[k] = tap_ff[k+1];
         end
         tap_in[TAPS] = tap_ff[0];
      end

      // rotate the coefficients, replacing the head when updating
      if (coef_rot) begin
         for (int k = 0; k < TAPS - 1; k++) begin
            coef_in[k] = coef_ff[k+1];
         end
         coef_in[TAPS-1] = coef_wr ? coef_new : coef_ff[0];
      end

      // retire the registered product
      case (mul_tag)
         TAG_A:   acc_a_in = acc_a_ff + $signed(mul_prod[ENERGY_W-1:0]);
         TAG_B:   acc_b_in = acc_b_ff + $signed(mul_prod[ENERGY_W-1:0]);
         TAG_C:   acc_c_in = acc_c_ff + $signed(mul_prod[ENERGY_W-1:0]);
         TAG_Y1:  y1_in    = y1_ff + $signed(mul_prod[YACC_W-1:0]);
         TAG_Y2:  y2_in    = y2_ff + $signed(mul_prod[YACC_W-1:0]);
         TAG_BC:  bc_in    = $signed(mul_prod[BC_W-1:0]);
         TAG_AA:  den_in   = det[BC_W-1] ? EPS_Q40 : det[DEN_W-1:0] + EPS_Q40;
         TAG_E1C: tmp_in   = $signed(mul_prod[NUM_W-1:0]);
         TAG_E2A: numa_in  = tmp_ff - $signed(mul_prod[NUM_W-1:0]);
         TAG_E2B: tmp_in   = $signed(mul_prod[NUM_W-1:0]);
         TAG_E1A: numb_in  = tmp_ff - $signed(mul_prod[NUM_W-1:0]);
         TAG_WU:  s_in     = $signed(mul_prod[YACC_W-1:0]);
         TAG_WV:  s_in     = s_ff + $signed(mul_prod[YACC_W-1:0]);
         TAG_STP: delta_in = $signed(dr[BC_W-1:16]);
         default: ;
      endcase

      // round the a-priori outputs, form errors, scale the energies
      if (state_ff == ST_ERR) begin
         fo_in = sat16(29'(y1q));
         e1_in = sat16(29'(d1_ff) - 29'(y1q));
         e2_in = sat16(29'(d2_ff) - 29'(y2q));
         as_in = $signed(acc_a_ff[ENERGY_W-1:10]);
         bs_in = $signed(acc_b_ff[ENERGY_W-1:10]);
         cs_in = $signed(acc_c_ff[ENERGY_W-1:10]);
      end

      // round the per-tap step to Q12.28 and clamp
      if (state_ff == ST_UPD && sub_ff == UPD_ROUND) begin
         if (s_rnd > 50'(WEIGHT_MAX)) begin
            s28_in = WEIGHT_MAX;
         end else if (s_rnd < -50'(WEIGHT_MAX)) begin
            s28_in = -WEIGHT_MAX;
         end else begin
            s28_in = s_rnd[WEIGHT_W-1:0];
         end
      end

      // capture the step weights
      if (state_ff == ST_DIV_A_WAIT && div_stat.done) begin
         wa_in = div_quot;
      end
      if (state_ff == ST_DIV_B_WAIT && div_stat.done) begin
         wb_in = div_quot;
      end
   end

   // sequencer counters
   always_comb begin
      sub_in = '0;
      idx_in = '0;
      if (state_ff == ST_DOT || state_ff == ST_DET || state_ff == ST_UPD) begin
         sub_in = last_sub ? '0 : sub_ff + 1'b1;
         idx_in = last_sub ? idx_ff + 1'b1 : idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sub_ff    <= '0;
         idx_ff    <= '0;
         prev_d_ff <= '0;
         step_ff   <= STEP_RESET;
         for (int k = 0; k <= TAPS; k++) begin
            tap_ff[k] <= '0;
         end
         for (int k = 0; k < TAPS; k++) begin
            coef_ff[k] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         sub_ff    <= sub_in;
         idx_ff    <= idx_in;
         prev_d_ff <= prev_d_in;
         step_ff   <= step_in;
         tap_ff    <= tap_in;
         coef_ff   <= coef_in;
      end
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
      acc_c_ff <= acc_c_in;
      y1_ff    <= y1_in;
      y2_ff    <= y2_in;
      as_ff    <= as_in;
      bs_ff    <= bs_in;
      cs_ff    <= cs_in;
      e1_ff    <= e1_in;
      e2_ff    <= e2_in;
      fo_ff    <= fo_in;
      bc_ff    <= bc_in;
      den_ff   <= den_in;
      tmp_ff   <= tmp_in;
      numa_ff  <= numa_in;
      numb_ff  <= numb_in;
      wa_ff    <= wa_in;
      wb_ff    <= wb_in;
      s_ff     <= s_in;
      s28_ff   <= s28_in;
      delta_ff <= delta_in;
   end

   // result and register read
   assign rsp_filter_out = fo_ff;
   assign rsp_error_out  = e1_ff;
   assign csr_pready     = 1'b1;
   assign csr_prdata     = (csr_paddr[CSR_ADDR_W-1:2] == REG_STEP_SIZE) ?
                           CSR_DATA_W'(step_ff) : '0;

   // one item in flight: no new item while a result waits
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result is pending");

   // an accepted item keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held after taking an item");

   // the divisor always carries the regularization term
   a_den_floor: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> (den_ff >= EPS_Q40))
      else $error("divisor below regularization floor");

   // a divider result only arrives while the sequencer waits for it
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV_A_WAIT || state_ff == ST_DIV_B_WAIT))
      else $error("divider finished outside a wait state");

   // a taken result returns the block to idle
   a_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("block not idle after result taken");

endmodule

`default_nettype wire
